>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the signature scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define MBSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition on one edge is followed by another on the next edge.
`define MBSS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mbss_pkg.sv
// Package of the signature scanner: sizes, register indexes and transaction types.
`default_nettype none
package mbss_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int ADDRESS_BITS      = 32;

    localparam int IDX_BITS     = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_BITS     = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int LENGTH_BITS  = 6;
    localparam int CARE_BITS    = 32;
    localparam int CFG_BITS     = 64;
    localparam int CFG_IDX_BITS = 3;
    localparam int PATTERN_REGS = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CARE_MASK = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH    = 3'd5;

    typedef struct packed {
        logic [7:0]              data_byte;
        logic [ADDRESS_BITS-1:0] byte_address;
        logic                    region_start;
        logic                    scan_start;
        logic                    scan_end;
    } in_t;

    typedef struct packed {
        logic                    found;
        logic [ADDRESS_BITS-1:0] match_address;
    } out_t;

    typedef struct packed {
        logic [PATTERN_REGS*CFG_BITS-1:0] pattern;
        logic [CARE_BITS-1:0]             care_mask;
        logic [LENGTH_BITS-1:0]           length;
    } cfg_t;

endpackage
`default_nettype wire

>>> hdl/mbss_cfg_regs.sv
// Configuration register file of the signature scanner.
`default_nettype none
module mbss_cfg_regs (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [mbss_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [mbss_pkg::CFG_BITS-1:0]         cfg_data,
    output mbss_pkg::cfg_t                             cfg
);

    logic [mbss_pkg::CFG_BITS-1:0]    pattern_reg [mbss_pkg::PATTERN_REGS];
    logic [mbss_pkg::CARE_BITS-1:0]   care_reg;
    logic [mbss_pkg::LENGTH_BITS-1:0] length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < mbss_pkg::PATTERN_REGS; r++)
            begin
                pattern_reg[r] <= '0;
            end
            care_reg   <= '1;
            length_reg <= mbss_pkg::LENGTH_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbss_pkg::CFG_PATTERN_0: pattern_reg[0] <= cfg_data;
                mbss_pkg::CFG_PATTERN_1: pattern_reg[1] <= cfg_data;
                mbss_pkg::CFG_PATTERN_2: pattern_reg[2] <= cfg_data;
                mbss_pkg::CFG_PATTERN_3: pattern_reg[3] <= cfg_data;
                mbss_pkg::CFG_CARE_MASK: care_reg   <= cfg_data[mbss_pkg::CARE_BITS-1:0];
                mbss_pkg::CFG_LENGTH:    length_reg <= cfg_data[mbss_pkg::LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < mbss_pkg::PATTERN_REGS; r++)
        begin
            cfg.pattern[r*mbss_pkg::CFG_BITS +: mbss_pkg::CFG_BITS] = pattern_reg[r];
        end
        cfg.care_mask = care_reg;
        cfg.length    = length_reg;
    end

endmodule
`default_nettype wire

>>> hdl/mbss_window.sv
// Byte window, fill count and masked parallel compare of the signature scanner.
`default_nettype none
module mbss_window (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  mbss_pkg::in_t       in_data,
    input  mbss_pkg::cfg_t      cfg,
    output logic                res_valid,
    output mbss_pkg::out_t      res_data
);

    logic [7:0]                  window_reg [mbss_pkg::MAX_PATTERN_BYTES];
    logic [7:0]                  win_shift  [mbss_pkg::MAX_PATTERN_BYTES];
    logic [mbss_pkg::LEN_BITS-1:0] fill_reg, fill_next, fill_base;
    logic                        seen_reg, seen_next, seen_base;
    logic [mbss_pkg::LEN_BITS-1:0] len;
    logic [mbss_pkg::LEN_BITS-1:0] offset;
    logic [mbss_pkg::MAX_PATTERN_BYTES-1:0] pos_ok;
    logic                        hit;

    // Active length: zero acts as one, anything above the window size as the window size.
    always_comb
    begin
        if (cfg.length == '0)
        begin
            len = mbss_pkg::LEN_BITS'(1);
        end
        else if (cfg.length > mbss_pkg::LENGTH_BITS'(mbss_pkg::MAX_PATTERN_BYTES))
        begin
            len = mbss_pkg::LEN_BITS'(mbss_pkg::MAX_PATTERN_BYTES);
        end
        else
        begin
            len = mbss_pkg::LEN_BITS'(cfg.length);
        end
    end

    always_comb
    begin
        win_shift[0] = in_data.data_byte;
        for (int k = 1; k < mbss_pkg::MAX_PATTERN_BYTES; k++)
        begin
            win_shift[k] = window_reg[k-1];
        end
    end

    // A scan start or region start empties the window before the byte goes in.
    always_comb
    begin
        seen_base = in_data.scan_start ? 1'b0 : seen_reg;
        fill_base = (in_data.scan_start || in_data.region_start) ? '0 : fill_reg;
        if (fill_base == mbss_pkg::LEN_BITS'(mbss_pkg::MAX_PATTERN_BYTES))
        begin
            fill_next = fill_base;
        end
        else
        begin
            fill_next = fill_base + mbss_pkg::LEN_BITS'(1);
        end
    end

    // Signature byte i lines up with the window byte len-1-i, the oldest of the match.
    always_comb
    begin
        offset = '0;
        for (int i = 0; i < mbss_pkg::MAX_PATTERN_BYTES; i++)
        begin
            offset = len - mbss_pkg::LEN_BITS'(1) - mbss_pkg::LEN_BITS'(i);
            if ((mbss_pkg::LEN_BITS'(i) < len) && cfg.care_mask[i])
            begin
                pos_ok[i] = (win_shift[offset[mbss_pkg::IDX_BITS-1:0]]
                             == cfg.pattern[i*8 +: 8]);
            end
            else
            begin
                pos_ok[i] = 1'b1;
            end
        end
        hit = (&pos_ok) && (fill_next >= len);
    end

    always_comb
    begin
        res_valid = accept && !seen_base && (hit || in_data.scan_end);
        res_data.found = hit;
        if (hit)
        begin
            res_data.match_address = in_data.byte_address
                                     - mbss_pkg::ADDRESS_BITS'(len - mbss_pkg::LEN_BITS'(1));
        end
        else
        begin
            res_data.match_address = '0;
        end
        seen_next = seen_base || res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
        end
    end

    // Window bytes are only read once the fill count covers them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < mbss_pkg::MAX_PATTERN_BYTES; k++)
            begin
                window_reg[k] <= win_shift[k];
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/mbss_out_fifo.sv
// Two-entry result queue that decouples the output side from the byte stream.
`default_nettype none
module mbss_out_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  mbss_pkg::out_t  push_data,
    output logic            full,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mbss_pkg::out_t  out_data
);

    mbss_pkg::out_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/masked_byte_signature_scanner.sv
// Top level of the masked byte signature scanner.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid / in_ready     in_data   (mbss_pkg::in_t)
//   out       output     out_valid / out_ready   out_data  (mbss_pkg::out_t)
//   cfg       input      cfg_write               cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; it is compared with the window in
// the accepting cycle, and a result, if any, is queued behind any older pending results.
// Reset empties the window and the result queue and loads the register defaults.
// The result queue holds two entries, so input transactions keep flowing while a
// result waits; in_ready drops only when both entries are occupied.
`default_nettype none
module masked_byte_signature_scanner (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  mbss_pkg::in_t                          in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mbss_pkg::out_t                         out_data,
    input  wire logic                              cfg_write,
    input  wire logic [mbss_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [mbss_pkg::CFG_BITS-1:0]     cfg_data
);

    mbss_pkg::cfg_t cfg;
    mbss_pkg::out_t res_data;
    logic           res_valid;
    logic           accept;
    logic           full;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    mbss_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbss_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    mbss_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> hdl/mbss_checker.sv
// Port-level checker of the signature scanner and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module mbss_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_ready,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  mbss_pkg::out_t      out_data
);

    // A not-found transaction never carries an address.
    `MBSS_ASSERT(a_notfound_zero, out_valid && !out_data.found |-> out_data.match_address == '0, "not-found result with non-zero address")

    // Input is only held off while a result is waiting.
    `MBSS_ASSERT(a_ready_low_needs_result, !in_ready |-> out_valid, "input stalled with no result pending")

    // A stalled result stays on the port.
    `MBSS_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result dropped or changed")

    // An accepted byte can add at most one result, so a full queue drains first.
    `MBSS_ASSERT_NEXT(a_no_accept_when_full, !in_ready && !out_ready, !in_ready, "input accepted while the result queue stayed full")

endmodule

bind masked_byte_signature_scanner mbss_checker u_mbss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the masked byte signature scanner.
`timescale 1ns / 100ps

module tb;

    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_SETTING = 72;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mbss_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mbss_pkg::out_t out_data;
    logic cfg_write = 1'b0;
    logic [mbss_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [mbss_pkg::CFG_BITS-1:0] cfg_data = '0;

    masked_byte_signature_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the register file and of the scanning state.
    logic [mbss_pkg::CFG_BITS-1:0] sig_regs [mbss_pkg::PATTERN_REGS] = '{default: '0};
    logic [mbss_pkg::CARE_BITS-1:0] care_bits = '1;
    logic [mbss_pkg::LENGTH_BITS-1:0] sig_length = 6'd1;
    logic [7:0] recent_bytes [mbss_pkg::MAX_PATTERN_BYTES] = '{default: '0};
    int unsigned fill_count = 0;
    bit scan_done = 1'b0;

    mbss_pkg::in_t byte_feed [$];
    mbss_pkg::out_t expected_reports [$];
    int feed_idle_pct = 0;
    int report_stall_pct = 0;
    int fed_count = 0;
    int errors = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int effective_length();
        int l;
        l = sig_length;
        if (l == 0)
            l = 1;
        if (l > mbss_pkg::MAX_PATTERN_BYTES)
            l = mbss_pkg::MAX_PATTERN_BYTES;
        return l;
    endfunction

    function automatic logic [7:0] signature_byte(int i);
        return sig_regs[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Takes one accepted byte into the window and queues the report it causes, if any.
    function automatic void advance_signature_window(mbss_pkg::in_t b);
        int l;
        bit hit;
        mbss_pkg::out_t r;
        l = effective_length();
        if (b.scan_start)
        begin
            scan_done = 1'b0;
            fill_count = 0;
        end
        if (b.region_start)
            fill_count = 0;
        for (int k = mbss_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k - 1];
        recent_bytes[0] = b.data_byte;
        if (fill_count < mbss_pkg::MAX_PATTERN_BYTES)
            fill_count++;
        if (scan_done)
            return;
        hit = (fill_count >= l);
        if (hit)
        begin
            // The oldest byte of the window lines up with signature byte 0.
            for (int i = 0; i < l; i++)
                if (care_bits[i] && recent_bytes[l - 1 - i] != signature_byte(i))
                    hit = 1'b0;
        end
        if (hit)
        begin
            scan_done = 1'b1;
            r.found = 1'b1;
            r.match_address = b.byte_address - mbss_pkg::ADDRESS_BITS'(l - 1);
            expected_reports.push_back(r);
        end
        else if (b.scan_end)
        begin
            scan_done = 1'b1;
            r = '0;
            expected_reports.push_back(r);
        end
    endfunction

    // Input driver: holds each transaction until it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                advance_signature_window(in_data);
            if (!in_valid || in_ready)
            begin
                if (byte_feed.size() > 0 && $urandom_range(0, 99) >= feed_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= byte_feed.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : report_check
        mbss_pkg::out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result: found %0d, match_address %h",
                           out_data.found, out_data.match_address);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_data.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, out_data.found);
                        errors++;
                    end
                    if (out_data.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, actual %h",
                               want.match_address, out_data.match_address);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= report_stall_pct);
        end
    end

    task automatic write_reg(logic [mbss_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [mbss_pkg::CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            mbss_pkg::CFG_PATTERN_0: sig_regs[0] = value;
            mbss_pkg::CFG_PATTERN_1: sig_regs[1] = value;
            mbss_pkg::CFG_PATTERN_2: sig_regs[2] = value;
            mbss_pkg::CFG_PATTERN_3: sig_regs[3] = value;
            mbss_pkg::CFG_CARE_MASK: care_bits = value[mbss_pkg::CARE_BITS-1:0];
            mbss_pkg::CFG_LENGTH:    sig_length = value[mbss_pkg::LENGTH_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [mbss_pkg::CFG_BITS-1:0] p0,
                                logic [mbss_pkg::CFG_BITS-1:0] p1,
                                logic [mbss_pkg::CFG_BITS-1:0] p2,
                                logic [mbss_pkg::CFG_BITS-1:0] p3,
                                logic [mbss_pkg::CARE_BITS-1:0] care,
                                logic [mbss_pkg::LENGTH_BITS-1:0] len);
        logic [mbss_pkg::CFG_BITS-1:0] junk;
        // Bits above the care-mask and length register widths are filled with noise; they must be ignored.
        junk = {$urandom, $urandom};
        write_reg(mbss_pkg::CFG_PATTERN_0, p0);
        write_reg(mbss_pkg::CFG_PATTERN_1, p1);
        write_reg(mbss_pkg::CFG_PATTERN_2, p2);
        write_reg(mbss_pkg::CFG_PATTERN_3, p3);
        write_reg(mbss_pkg::CFG_CARE_MASK, {junk[63:32], care});
        write_reg(mbss_pkg::CFG_LENGTH, {junk[63:6], len});
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic pick_setting(int k);
        logic [5:0] len;
        logic [31:0] care;
        case (k)
            0: load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, '1, 6'd32);
            1: load_setting('0, '0, '0, '0, $urandom, 6'd0);
            2: load_setting('1, '1, '1, '1, '0, 6'd63);
            3: load_setting('1, '1, '1, '1, '1, 6'd1);
            4: load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, $urandom, 6'd33);
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(9, 32);
                else
                    len = $urandom_range(1, 8);
                care = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom | $urandom);
                load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, care, len);
            end
        endcase
    endtask

    task automatic add_byte(logic [7:0] d, logic [31:0] a, bit region, bit first, bit last);
        mbss_pkg::in_t b;
        b.data_byte = d;
        b.byte_address = a;
        b.region_start = region;
        b.scan_start = first;
        b.scan_end = last;
        byte_feed.push_back(b);
        fed_count++;
    endtask

    // One scan of random bytes, usually with the signature planted somewhere in it.
    task automatic add_scan();
        logic [7:0] dat [128];
        bit breaks [128];
        int n, l, p;
        bit noisy, region, first, last;
        logic [31:0] addr;
        noisy = ($urandom_range(0, 99) < 15);
        l = effective_length();
        for (int j = 0; j < 128; j++)
        begin
            dat[j] = $urandom;
            breaks[j] = noisy ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 29) == 0);
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 90) : $urandom_range(1, 24);
        if ($urandom_range(0, 99) < 75)
        begin
            if (n < l)
                n = l + $urandom_range(0, 6);
            p = $urandom_range(0, n - l);
            for (int j = 0; j < l; j++)
                if (care_bits[j])
                    dat[p + j] = signature_byte(j);
            // Now and then a single bit is flipped to give a near miss.
            if ($urandom_range(0, 4) == 0)
                dat[p + $urandom_range(0, l - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        addr = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20) : $urandom;
        for (int j = 0; j < n; j++)
        begin
            if (j > 0 && breaks[j])
                addr = $urandom;
            region = noisy ? breaks[j] : (j == 0 || breaks[j]);
            first = noisy ? ($urandom_range(0, 9) == 0) : (j == 0);
            last = noisy ? ($urandom_range(0, 9) == 0) : (j == n - 1);
            add_byte(dat[j], addr, region, first, last);
            addr++;
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_feed.size() != 0 || in_valid || expected_reports.size() != 0);
        // Bytes that cause no result may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int idle_in [4];
        int idle_out [4];
        idle_in = '{0, 73, 0, 20};
        idle_out = '{0, 0, 73, 20};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Signature DE ?? BE EF; care bits above the length are set but must not count.
        load_setting(64'h1122_3344_EFBE_ADDE, '1, '1, '1, 32'hFFFF_FFFD, 6'd4);
        // Match before any scan has started, with the start address wrapping.
        add_byte(8'hDE, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0);
        add_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBE, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        add_byte(8'hEF, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFF, 32'h0000_0002, 1'b0, 1'b0, 1'b1);
        // A region start splits the signature, then a near miss ends the scan.
        add_byte(8'hDE, 32'h0000_0100, 1'b1, 1'b1, 1'b0);
        add_byte(8'h55, 32'h0000_0101, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBE, 32'h0000_0102, 1'b0, 1'b0, 1'b0);
        add_byte(8'hEF, 32'h0000_0500, 1'b1, 1'b0, 1'b0);
        add_byte(8'hDE, 32'h0000_0501, 1'b0, 1'b0, 1'b0);
        add_byte(8'hAA, 32'h0000_0502, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBE, 32'h0000_0503, 1'b0, 1'b0, 1'b0);
        add_byte(8'hEE, 32'h0000_0504, 1'b0, 1'b0, 1'b1);
        // Match on the last byte of the scan.
        add_byte(8'hDE, 32'h0000_0010, 1'b1, 1'b1, 1'b0);
        add_byte(8'hFF, 32'h0000_0011, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBE, 32'h0000_0012, 1'b0, 1'b0, 1'b0);
        add_byte(8'hEF, 32'h0000_0013, 1'b0, 1'b0, 1'b1);
        // A one-byte scan.
        add_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        // A second scan start in the middle of the signature empties the window.
        add_byte(8'hDE, 32'h0000_0020, 1'b0, 1'b1, 1'b0);
        add_byte(8'h00, 32'h0000_0021, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBE, 32'h0000_0022, 1'b0, 1'b1, 1'b0);
        add_byte(8'hEF, 32'h0000_0023, 1'b0, 1'b0, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            feed_idle_pct = idle_in[phase];
            report_stall_pct = idle_out[phase];
            for (int s = 0; s < 4; s++)
            begin
                pick_setting(phase * 4 + s);
                fed_count = 0;
                while (fed_count < ITEMS_PER_SETTING)
                    add_scan();
                wait_idle();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #400_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
